FILE: design/mcvt_pkg.sv
// Shared types and constants for the MIDI controller value tracker.
// Holds the request/response item structs, host command and table op codes.
// No dependencies.
`default_nettype none

package mcvt_pkg;

   localparam int INDEX_WIDTH = 11;
   localparam int TABLE_DEPTH = 2 ** INDEX_WIDTH;
   localparam int VALUE_WIDTH = 7;
   localparam int ENTRY_WIDTH = VALUE_WIDTH + 1;

   localparam logic [7:0] VOICE_FIRST  = 8'h80;
   localparam logic [7:0] VOICE_LAST   = 8'hEF;
   localparam logic [7:0] SYSCOM_FIRST = 8'hF0;
   localparam logic [7:0] SYSCOM_LAST  = 8'hF7;
   localparam logic [7:0] CC_STATUS    = 8'hB0;
   localparam logic [3:0] CHANNEL_MASK = 4'hF;

   typedef enum logic [1:0] {
      CMD_MIDI   = 2'd0,
      CMD_ADD    = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_READ   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_ADD,
      OP_REMOVE,
      OP_READ,
      OP_UPDATE
   } op_code_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] midi_byte;
      logic [3:0] channel;
      logic [6:0] controller_number;
   } mcvt_req_type;

   typedef struct packed {
      logic       traced;
      logic [6:0] value;
      logic       updated;
      logic [3:0] updated_channel;
      logic [6:0] updated_controller;
   } mcvt_rsp_type;

   typedef struct packed {
      op_code_type            code;
      logic [INDEX_WIDTH-1:0] index;
      logic [VALUE_WIDTH-1:0] data;
   } mcvt_op_type;

endpackage

`default_nettype wire

FILE: design/mcvt_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module mcvt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048,
   localparam int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [ADDR_WIDTH-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]      wr_data,
   input  wire logic                  rd_en,
   input  wire logic [ADDR_WIDTH-1:0] rd_addr,
   output logic      [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: design/mcvt_queue.sv
// Small FIFO of table ops between the parser front and the table back end.
// Depends on mcvt_pkg for the op type.
`default_nettype none

module mcvt_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push_valid,
   output logic                      push_ready,
   input  wire mcvt_pkg::mcvt_op_type push_op,
   output logic                      pop_valid,
   input  wire logic                 pop,
   output mcvt_pkg::mcvt_op_type     pop_op
);
   import mcvt_pkg::*;

   localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0] LAST_PTR = PTR_WIDTH'(DEPTH - 1);
   localparam logic [CNT_WIDTH-1:0] FULL_CNT = CNT_WIDTH'(DEPTH);

   mcvt_op_type            entries_ff [DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_op     = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop & pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_op;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/mcvt_front.sv
// Front end: accepts items, runs the MIDI running-status parser and turns each
// item into one table op. Depends on mcvt_pkg.
`default_nettype none

module mcvt_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire mcvt_pkg::mcvt_req_type req_data,
   input  wire logic                 clearing,
   input  wire logic                 push_ready,
   output logic                      push_valid,
   output mcvt_pkg::mcvt_op_type     push_op
);
   import mcvt_pkg::*;

   logic [7:0] running_status_ff, running_status_in;
   logic       cc_valid_ff, cc_valid_in;
   logic [3:0] cc_channel_ff, cc_channel_in;
   logic       pending_valid_ff, pending_valid_in;
   logic [6:0] pending_number_ff, pending_number_in;
   logic [7:0] b;

   assign req_ready  = push_ready & ~clearing;
   assign push_valid = req_valid & req_ready;
   assign b          = req_data.midi_byte;

   always_comb begin
      running_status_in = running_status_ff;
      cc_valid_in       = cc_valid_ff;
      cc_channel_in     = cc_channel_ff;
      pending_valid_in  = pending_valid_ff;
      pending_number_in = pending_number_ff;
      push_op.code      = OP_NONE;
      push_op.index     = {req_data.channel, req_data.controller_number};
      push_op.data      = b[6:0];
      case (req_data.cmd)
         CMD_ADD:    push_op.code = OP_ADD;
         CMD_REMOVE: push_op.code = OP_REMOVE;
         CMD_READ:   push_op.code = OP_READ;
         default: begin
            if (b inside {[VOICE_FIRST:VOICE_LAST]}) begin
               running_status_in = b;
               pending_valid_in  = 1'b0;
               pending_number_in = '0;
               if ((b & CC_STATUS) == CC_STATUS) begin
                  cc_valid_in   = 1'b1;
                  cc_channel_in = b[3:0] & CHANNEL_MASK;
               end else begin
                  cc_valid_in   = 1'b0;
                  cc_channel_in = '0;
               end
            end else if (b inside {[SYSCOM_FIRST:SYSCOM_LAST]}) begin
               running_status_in = '0;
               cc_valid_in       = 1'b0;
               cc_channel_in     = '0;
               pending_valid_in  = 1'b0;
               pending_number_in = '0;
            end else if (!b[7] && running_status_ff != '0 && cc_valid_ff) begin
               if (!pending_valid_ff) begin
                  pending_valid_in  = 1'b1;
                  pending_number_in = b[6:0];
               end else begin
                  push_op.code      = OP_UPDATE;
                  push_op.index     = {cc_channel_ff, pending_number_ff};
                  pending_valid_in  = 1'b0;
                  pending_number_in = '0;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_status_ff <= '0;
         cc_valid_ff       <= 1'b0;
         cc_channel_ff     <= '0;
         pending_valid_ff  <= 1'b0;
         pending_number_ff <= '0;
      end else if (push_valid) begin
         running_status_ff <= running_status_in;
         cc_valid_ff       <= cc_valid_in;
         cc_channel_ff     <= cc_channel_in;
         pending_valid_ff  <= pending_valid_in;
         pending_number_ff <= pending_number_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/mcvt_back.sv
// Back end: clears the trace table after reset, then carries out table ops
// one at a time and drives the response register. Depends on mcvt_pkg, mcvt_ram.
`default_nettype none

module mcvt_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 pop_valid,
   output logic                      pop,
   input  wire mcvt_pkg::mcvt_op_type pop_op,
   output logic                      clearing,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output mcvt_pkg::mcvt_rsp_type    rsp_data
);
   import mcvt_pkg::*;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WAIT
   } state_type;

   localparam logic [INDEX_WIDTH-1:0] LAST_INDEX = INDEX_WIDTH'(TABLE_DEPTH - 1);

   state_type              state_ff, state_in;
   logic [INDEX_WIDTH-1:0] clear_addr_ff, clear_addr_in;
   mcvt_op_type            op_hold_ff, op_hold_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   mcvt_rsp_type           rsp_ff, rsp_in;
   logic                   out_free;
   logic                   wr_en, rd_en;
   logic [INDEX_WIDTH-1:0] wr_addr, rd_addr;
   logic [ENTRY_WIDTH-1:0] wr_data, rd_data;
   logic                   entry_traced;

   mcvt_ram #(
      .WIDTH (ENTRY_WIDTH),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free     = ~rsp_valid_ff | rsp_ready;
   assign entry_traced = rd_data[ENTRY_WIDTH-1];
   assign clearing     = (state_ff == ST_CLEAR);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;

   always_comb begin
      state_in      = state_ff;
      clear_addr_in = clear_addr_ff;
      op_hold_in    = op_hold_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_in        = rsp_ff;
      pop           = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = pop_op.index;
      wr_data       = '0;
      rd_en         = 1'b0;
      rd_addr       = pop_op.index;
      case (state_ff)
         ST_CLEAR: begin
            wr_en         = 1'b1;
            wr_addr       = clear_addr_ff;
            clear_addr_in = clear_addr_ff + 1'b1;
            if (clear_addr_ff == LAST_INDEX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (pop_valid && out_free) begin
               pop = 1'b1;
               case (pop_op.code)
                  OP_ADD: begin
                     wr_en        = 1'b1;
                     wr_data      = {1'b1, {VALUE_WIDTH{1'b0}}};
                     rsp_valid_in = 1'b1;
                     rsp_in       = '0;
                  end
                  OP_REMOVE: begin
                     wr_en        = 1'b1;
                     rsp_valid_in = 1'b1;
                     rsp_in       = '0;
                  end
                  OP_READ, OP_UPDATE: begin
                     rd_en      = 1'b1;
                     op_hold_in = pop_op;
                     state_in   = ST_WAIT;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '0;
                  end
               endcase
            end
         end
         ST_WAIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               state_in     = ST_IDLE;
               if (entry_traced) begin
                  if (op_hold_ff.code == OP_UPDATE) begin
                     wr_en                     = 1'b1;
                     wr_addr                   = op_hold_ff.index;
                     wr_data                   = {1'b1, op_hold_ff.data};
                     rsp_in.value              = op_hold_ff.data;
                     rsp_in.updated            = 1'b1;
                     rsp_in.updated_channel    = op_hold_ff.index[INDEX_WIDTH-1:VALUE_WIDTH];
                     rsp_in.updated_controller = op_hold_ff.index[VALUE_WIDTH-1:0];
                  end else begin
                     rsp_in.traced = 1'b1;
                     rsp_in.value  = rd_data[VALUE_WIDTH-1:0];
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      op_hold_ff <= op_hold_in;
      rsp_ff     <= rsp_in;
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/midi_controller_value_tracker.sv
// Top level of the MIDI controller value tracker: parser front, op queue, table back end.
// Depends on mcvt_pkg, mcvt_front, mcvt_queue, mcvt_back.
//
// Each item is a received MIDI byte or a host add/remove/read of a traced
// (channel, controller) pair, and gives exactly one response item. After reset
// the block clears its 2048-entry trace table, one entry a cycle, with req_ready
// low. The front parses one item a cycle, while the queue has room, into a queue
// of QUEUE_DEPTH table ops; the back end owns the single table RAM, whose read is
// registered. Add, remove and MIDI bytes that touch no entry are done from ST_IDLE
// in the back end; reads and controller value bytes go through ST_IDLE (table
// read), then ST_WAIT (response and write-back), one op at a time.
`default_nettype none

module midi_controller_value_tracker #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire mcvt_pkg::mcvt_req_type req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output mcvt_pkg::mcvt_rsp_type      rsp_data
);
   import mcvt_pkg::*;

   logic        clearing;
   logic        push_valid, push_ready;
   mcvt_op_type push_op;
   logic        pop_valid, pop;
   mcvt_op_type pop_op;

   mcvt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .clearing   (clearing),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_op    (push_op)
   );

   mcvt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_op    (push_op),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_op     (pop_op)
   );

   mcvt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop       (pop),
      .pop_op    (pop_op),
      .clearing  (clearing),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

FILE: design/mcvt_checker.sv
// Port-level checker for the MIDI controller value tracker, with its bind.
// Depends on mcvt_pkg and midi_controller_value_tracker.
`default_nettype none

module mcvt_checker #(
   parameter int QUEUE_DEPTH = 2
) (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_ready,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire mcvt_pkg::mcvt_rsp_type rsp_data
);
   import mcvt_pkg::*;

   localparam int MAX_OPEN = QUEUE_DEPTH + 2;
   localparam int CNT_WIDTH = $clog2(MAX_OPEN + 1) + 1;
   localparam logic [CNT_WIDTH-1:0] MAX_CNT = CNT_WIDTH'(MAX_OPEN);

   logic [CNT_WIDTH-1:0] open_ff, open_in;
   logic                 req_take, rsp_take;

   assign req_take = req_valid & req_ready;
   assign rsp_take = rsp_valid & rsp_ready;

   always_comb begin
      open_in = open_ff;
      if (req_take && !rsp_take) begin
         open_in = open_ff + 1'b1;
      end else if (rsp_take && !req_take) begin
         open_in = open_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   a_clear_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready)
      else $error("item taken during table clear");

   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> open_ff != '0)
      else $error("response without an open item");

   a_open_bound: assert property (@(posedge clock) disable iff (reset)
      open_ff <= MAX_CNT)
      else $error("more open items than the block can hold");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

endmodule

bind midi_controller_value_tracker mcvt_checker #(
   .QUEUE_DEPTH (QUEUE_DEPTH)
) u_checker (.*);

`default_nettype wire
